// ----- hdl/mcrl_pkg.sv -----
// ----------------------------------------------------------------------------
// mcrl_pkg
// Shared types and codes for the multi-channel reading ring log.
// ----------------------------------------------------------------------------
`default_nettype none

package mcrl_pkg;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_DUMP  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STORE,
        ST_DUMP
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;    // latch request fields, read the subject's ring row
        logic store_wr;  // write reading and updated ring row
        logic emit;      // issue one dump result, advance walk
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic subj_ok;   // request subject is in range
        logic kind_ok;   // request kind is in range
        logic dump_done; // result issued now is the final one of the dump
    } t_stat;

endpackage

`default_nettype wire

// ----- hdl/multi_channel_reading_ring_log.sv -----
// ----------------------------------------------------------------------------
// multi_channel_reading_ring_log
// Per subject and kind ring of timestamped readings with ordered dump.
// ----------------------------------------------------------------------------
// Requests enter on start/busy: a request is taken at a clock edge with
// start high and busy low. i_op selects store or dump.
// Store: writes the reading into the ring of (subject, kind), overwriting
//   the oldest entry once the ring holds RING_DEPTH readings. The metadata
//   row is read at accept, then written back; busy is high for one cycle.
//   Out-of-range subject or kind is dropped; busy stays low.
// Dump: for each kind in order emits one empty marker or the kind's
//   readings oldest first; the final result has o_last set. The metadata
//   row is read in the accept cycle, then one result is issued per cycle
//   through a registered storage read into the result registers; busy
//   stays high until the final result is issued.
// Results carry o_valid for exactly one cycle; the receiver cannot stall.
// Reset clears the per-row valid bits (ring counts read as zero) and the
// output strobe; no clearing pass is needed. Stored readings are never
// read before written.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_reading_ring_log #(
    parameter int SUBJECTS   = 8,
    parameter int RING_DEPTH = 8,
    parameter int KINDS      = 5
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_op,
    input  wire logic [2:0]  i_subject,
    input  wire logic [2:0]  i_kind,
    input  wire logic [63:0] i_stamp,
    input  wire logic [15:0] i_reading,
    output logic             o_valid,
    output logic [2:0]       o_out_kind,
    output logic             o_is_empty,
    output logic [63:0]      o_out_stamp,
    output logic [15:0]      o_out_reading,
    output logic             o_last
);
    import mcrl_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    mcrl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_op    (i_op),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    mcrl_dpath #(
        .SUBJECTS   (SUBJECTS),
        .RING_DEPTH (RING_DEPTH),
        .KINDS      (KINDS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_subject     (i_subject),
        .i_kind        (i_kind),
        .i_stamp       (i_stamp),
        .i_reading     (i_reading),
        .o_valid       (o_valid),
        .o_out_kind    (o_out_kind),
        .o_is_empty    (o_is_empty),
        .o_out_stamp   (o_out_stamp),
        .o_out_reading (o_out_reading),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

// ----- hdl/mcrl_ctrl.sv -----
// ----------------------------------------------------------------------------
// mcrl_ctrl
// Request sequencer: accepts requests, runs store write-back and dump walk.
// ----------------------------------------------------------------------------
`default_nettype none

module mcrl_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire logic          i_op,
    input  wire mcrl_pkg::t_stat i_stat,
    output mcrl_pkg::t_cmd     o_cmd,
    output logic               busy
);
    import mcrl_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.accept = 1'b1;
                    if (i_op == OP_STORE) begin
                        if (i_stat.subj_ok && i_stat.kind_ok) begin
                            n_state = ST_STORE;
                        end
                    end else begin
                        // out-of-range subject: dump gives nothing
                        if (i_stat.subj_ok) begin
                            n_state = ST_DUMP;
                        end
                    end
                end
            end
            ST_STORE: begin
                o_cmd.store_wr = 1'b1;
                n_state        = ST_IDLE;
            end
            ST_DUMP: begin
                o_cmd.emit = 1'b1;
                if (i_stat.dump_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/mcrl_dpath.sv -----
// ----------------------------------------------------------------------------
// mcrl_dpath
// Ring metadata and reading storage, dump walk counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mcrl_dpath #(
    parameter int SUBJECTS   = 8,
    parameter int RING_DEPTH = 8,
    parameter int KINDS      = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire mcrl_pkg::t_cmd i_cmd,
    output mcrl_pkg::t_stat    o_stat,
    input  wire logic [2:0]    i_subject,
    input  wire logic [2:0]    i_kind,
    input  wire logic [63:0]   i_stamp,
    input  wire logic [15:0]   i_reading,
    output logic               o_valid,
    output logic [2:0]         o_out_kind,
    output logic               o_is_empty,
    output logic [63:0]        o_out_stamp,
    output logic [15:0]        o_out_reading,
    output logic               o_last
);
    import mcrl_pkg::*;

    localparam int SW      = (SUBJECTS > 1) ? $clog2(SUBJECTS) : 1;
    localparam int KW      = (KINDS > 1) ? $clog2(KINDS) : 1;
    localparam int CW      = $clog2(RING_DEPTH + 1);
    localparam int PW      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int ENTRIES = SUBJECTS * KINDS * RING_DEPTH;
    localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // ring metadata, one row per subject
    logic [KINDS-1:0][CW-1:0] r_cnt_mem  [SUBJECTS];
    logic [KINDS-1:0][PW-1:0] r_slot_mem [SUBJECTS];
    logic [SUBJECTS-1:0]      r_row_valid;

    // reading storage
    logic [63:0] r_stamp_mem [ENTRIES];
    logic [15:0] r_value_mem [ENTRIES];

    logic [SW-1:0]            r_subj;
    logic [KW-1:0]            r_kind;
    logic [63:0]              r_stamp;
    logic [15:0]              r_reading;
    logic [KINDS-1:0][CW-1:0] r_cnt_row;
    logic [KINDS-1:0][PW-1:0] r_slot_row;
    logic                     r_row_ok;
    logic [KW-1:0]            r_k;
    logic [CW-1:0]            r_j;

    logic                     r_p_valid;
    logic [2:0]               r_p_kind;
    logic                     r_p_empty;
    logic                     r_p_last;
    logic [63:0]              r_rd_stamp;
    logic [15:0]              r_rd_value;

    logic [SW-1:0]            subj_in;
    logic [KINDS-1:0][CW-1:0] cnt_row;
    logic [KINDS-1:0][PW-1:0] slot_row;
    logic [CW-1:0]            st_cnt;
    logic [PW-1:0]            st_slot;
    logic [KINDS-1:0][CW-1:0] new_cnt_row;
    logic [KINDS-1:0][PW-1:0] new_slot_row;
    logic [AW-1:0]            wr_addr;
    logic [CW-1:0]            dm_cnt;
    logic [PW-1:0]            dm_start;
    logic [PW:0]              dm_sum;
    logic [PW-1:0]            dm_slot;
    logic [AW-1:0]            rd_addr;
    logic                     kind_end;
    logic [CW-1:0]            j_inc;

    assign subj_in = SW'(i_subject);

    assign o_stat.subj_ok = (32'(i_subject) < SUBJECTS);
    assign o_stat.kind_ok = (32'(i_kind) < KINDS);

    // a row never written reads as all-zero counts and slots
    assign cnt_row  = r_row_ok ? r_cnt_row  : '0;
    assign slot_row = r_row_ok ? r_slot_row : '0;

    // store path
    always_comb begin
        st_cnt       = cnt_row[r_kind];
        st_slot      = slot_row[r_kind];
        new_cnt_row  = cnt_row;
        new_slot_row = slot_row;
        new_cnt_row[r_kind]  = (st_cnt == CW'(RING_DEPTH)) ? st_cnt : CW'(st_cnt + CW'(1));
        new_slot_row[r_kind] = (st_slot == PW'(RING_DEPTH - 1)) ? '0 : PW'(st_slot + PW'(1));
        wr_addr = AW'((32'(r_subj) * KINDS + 32'(r_kind)) * RING_DEPTH + 32'(st_slot));
    end

    // dump walk: oldest entry is slot 0 while filling, write slot once full
    always_comb begin
        dm_cnt   = cnt_row[r_k];
        dm_start = (dm_cnt == CW'(RING_DEPTH)) ? slot_row[r_k] : '0;
        dm_sum   = {1'b0, dm_start} + (PW + 1)'(r_j);
        dm_slot  = (dm_sum >= (PW + 1)'(RING_DEPTH)) ? PW'(dm_sum - (PW + 1)'(RING_DEPTH))
                                                     : PW'(dm_sum);
        rd_addr  = AW'((32'(r_subj) * KINDS + 32'(r_k)) * RING_DEPTH + 32'(dm_slot));
        j_inc    = CW'(r_j + CW'(1));
        kind_end = (dm_cnt == '0) || (j_inc == dm_cnt);
    end

    assign o_stat.dump_done = kind_end && (r_k == KW'(KINDS - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_subj    <= subj_in;
            r_kind    <= KW'(i_kind);
            r_stamp   <= i_stamp;
            r_reading <= i_reading;
            r_cnt_row  <= r_cnt_mem[subj_in];
            r_slot_row <= r_slot_mem[subj_in];
            r_row_ok   <= r_row_valid[subj_in];
            r_k        <= '0;
            r_j        <= '0;
        end else if (i_cmd.emit) begin
            if (kind_end) begin
                r_k <= KW'(r_k + KW'(1));
                r_j <= '0;
            end else begin
                r_j <= j_inc;
            end
        end
        if (i_cmd.store_wr) begin
            r_cnt_mem[r_subj]  <= new_cnt_row;
            r_slot_mem[r_subj] <= new_slot_row;
            r_stamp_mem[wr_addr] <= r_stamp;
            r_value_mem[wr_addr] <= r_reading;
        end
        r_rd_stamp <= r_stamp_mem[rd_addr];
        r_rd_value <= r_value_mem[rd_addr];
        r_p_kind   <= 3'(r_k);
        r_p_empty  <= (dm_cnt == '0);
        r_p_last   <= o_stat.dump_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_p_valid   <= 1'b0;
        end else begin
            if (i_cmd.store_wr) begin
                r_row_valid[r_subj] <= 1'b1;
            end
            r_p_valid <= i_cmd.emit;
        end
    end

    assign o_valid       = r_p_valid;
    assign o_out_kind    = r_p_kind;
    assign o_is_empty    = r_p_empty;
    assign o_out_stamp   = r_p_empty ? '0 : r_rd_stamp;
    assign o_out_reading = r_p_empty ? '0 : r_rd_value;
    assign o_last        = r_p_last;

endmodule

`default_nettype wire

// ----- verif/tb_multi_channel_reading_ring_log.sv -----
// ----------------------------------------------------------------------------
// tb_multi_channel_reading_ring_log
// Self-checking bench for the reading ring log. Requests go in over
// start/busy with random idle bursts; a scoreboard replays every accepted
// store and dump on its own copy of the rings and checks each dump result,
// field by field, in order of arrival.
// ----------------------------------------------------------------------------
module tb_multi_channel_reading_ring_log;
    import mcrl_pkg::*;

    localparam int N_SUBJECTS   = 8;
    localparam int N_DEPTH      = 8;
    localparam int N_KINDS      = 5;
    localparam int N_CHANNELS   = N_SUBJECTS * N_KINDS;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;

    localparam logic [2:0] KIND_TEMP   = 3'd0;
    localparam logic [2:0] KIND_HEART  = 3'd1;
    localparam logic [2:0] KIND_SYS    = 3'd2;
    localparam logic [2:0] KIND_DIA    = 3'd3;
    localparam logic [2:0] KIND_RESP   = 3'd4;
    localparam logic [2:0] KIND_BAD_LO = 3'd5;
    localparam logic [2:0] KIND_BAD_HI = 3'd7;

    typedef struct packed {
        logic [2:0]  kind;
        logic        empty;
        logic [63:0] stamp;
        logic [15:0] reading;
        logic        last;
    } t_dump_entry;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_op = OP_STORE;
    logic [2:0]  i_subject = '0;
    logic [2:0]  i_kind = '0;
    logic [63:0] i_stamp = '0;
    logic [15:0] i_reading = '0;
    logic        o_valid;
    logic [2:0]  o_out_kind;
    logic        o_is_empty;
    logic [63:0] o_out_stamp;
    logic [15:0] o_out_reading;
    logic        o_last;

    // scoreboard copy of the rings
    int unsigned ring_fill    [N_CHANNELS];
    int unsigned ring_wr_slot [N_CHANNELS];
    logic [63:0] ring_stamp   [N_CHANNELS][N_DEPTH];
    logic [15:0] ring_value   [N_CHANNELS][N_DEPTH];

    t_dump_entry pending_dump_q[$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          gaps_on = 1'b1;

    multi_channel_reading_ring_log #(
        .SUBJECTS   (N_SUBJECTS),
        .RING_DEPTH (N_DEPTH),
        .KINDS      (N_KINDS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_subject     (i_subject),
        .i_kind        (i_kind),
        .i_stamp       (i_stamp),
        .i_reading     (i_reading),
        .o_valid       (o_valid),
        .o_out_kind    (o_out_kind),
        .o_is_empty    (o_is_empty),
        .o_out_stamp   (o_out_stamp),
        .o_out_reading (o_out_reading),
        .o_last        (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d dump results still pending", $time,
                     pending_dump_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Update the rings for one accepted request; a dump queues its results.
    task automatic log_apply_request(input logic op, input logic [2:0] subj,
                                     input logic [2:0] knd, input logic [63:0] stmp,
                                     input logic [15:0] rdg);
        int unsigned ch;
        int unsigned slot;
        int unsigned oldest;
        t_dump_entry e;
        if (subj >= N_SUBJECTS)
            return;
        if (op == OP_STORE) begin
            if (knd >= N_KINDS)
                return;
            ch = subj * N_KINDS + knd;
            slot = ring_wr_slot[ch];
            ring_stamp[ch][slot] = stmp;
            ring_value[ch][slot] = rdg;
            ring_wr_slot[ch] = (slot + 1) % N_DEPTH;
            if (ring_fill[ch] < N_DEPTH)
                ring_fill[ch]++;
            return;
        end
        for (int k = 0; k < N_KINDS; k++) begin
            ch = subj * N_KINDS + k;
            e.kind = k[2:0];
            if (ring_fill[ch] == 0) begin
                e.empty   = 1'b1;
                e.stamp   = '0;
                e.reading = '0;
                e.last    = (k == N_KINDS - 1);
                pending_dump_q.push_back(e);
            end else begin
                // ring still filling: oldest is slot 0, else the next write slot
                oldest = (ring_fill[ch] < N_DEPTH) ? 0 : ring_wr_slot[ch];
                for (int j = 0; j < ring_fill[ch]; j++) begin
                    slot = (oldest + j) % N_DEPTH;
                    e.empty   = 1'b0;
                    e.stamp   = ring_stamp[ch][slot];
                    e.reading = ring_value[ch][slot];
                    e.last    = (k == N_KINDS - 1) && (j + 1 == ring_fill[ch]);
                    pending_dump_q.push_back(e);
                end
            end
        end
    endtask

    task automatic idle_gap(input int cycles);
        start     <= 1'b0;
        i_op      <= 1'($urandom);
        i_subject <= 3'($urandom);
        i_kind    <= 3'($urandom);
        i_stamp   <= {$urandom, $urandom};
        i_reading <= 16'($urandom);
        repeat (cycles) @(posedge i_clk);
    endtask

    // Called just after a rising edge; returns at the edge that took the request, or after a random idle gap.
    task automatic send_request(input logic op, input logic [2:0] subj,
                                input logic [2:0] knd, input logic [63:0] stmp,
                                input logic [15:0] rdg);
        bit taken;
        start     <= 1'b1;
        i_op      <= op;
        i_subject <= subj;
        i_kind    <= knd;
        i_stamp   <= stmp;
        i_reading <= rdg;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = (busy === 1'b0);
            @(posedge i_clk);
        end
        log_apply_request(op, subj, knd, stmp, rdg);
        if (gaps_on && $urandom_range(0, 3) == 0)
            idle_gap($urandom_range(1, 16));
    endtask

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name,
                     exp_v, act_v);
            error_count++;
        end
    endfunction

    // Results sit on the ports for one full cycle; sample mid-cycle.
    always @(negedge i_clk) begin : result_check
        t_dump_entry exp_e;
        if (i_rst_n && o_valid !== 1'b0) begin
            if (pending_dump_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual kind=%0d empty=%0b stamp=%0h reading=%0h last=%0b",
                         $time, o_out_kind, o_is_empty, o_out_stamp,
                         o_out_reading, o_last);
                error_count++;
            end else begin
                exp_e = pending_dump_q.pop_front();
                check_field("valid", 64'd1, 64'(o_valid));
                check_field("out_kind", 64'(exp_e.kind), 64'(o_out_kind));
                check_field("is_empty", 64'(exp_e.empty), 64'(o_is_empty));
                check_field("out_stamp", exp_e.stamp, o_out_stamp);
                check_field("out_reading", 64'(exp_e.reading), 64'(o_out_reading));
                check_field("last", 64'(exp_e.last), 64'(o_last));
            end
        end
    end

    task automatic test_empty_dumps();
        send_request(OP_DUMP, 3'd0, KIND_TEMP, '0, '0);
        // unused fields at their extremes must not matter
        send_request(OP_DUMP, 3'd7, KIND_BAD_HI, '1, 16'h8000);
    endtask

    task automatic test_store_extremes();
        send_request(OP_STORE, 3'd7, KIND_RESP, '0, 16'h8000);
        send_request(OP_STORE, 3'd7, KIND_RESP, '1, 16'h7FFF);
        send_request(OP_STORE, 3'd7, KIND_TEMP, 64'h8000_0000_0000_0001, 16'hFFFF);
        send_request(OP_DUMP, 3'd7, KIND_TEMP, '0, '0);
    endtask

    task automatic test_ignored_stores();
        send_request(OP_STORE, 3'd7, KIND_BAD_LO, {$urandom, $urandom}, 16'($urandom));
        send_request(OP_STORE, 3'd7, KIND_BAD_HI, {$urandom, $urandom}, 16'($urandom));
        send_request(OP_DUMP, 3'd7, KIND_RESP, '1, '1);
    endtask

    task automatic test_every_kind();
        send_request(OP_STORE, 3'd3, KIND_TEMP, "08:15:00", 16'sd371);
        send_request(OP_STORE, 3'd3, KIND_HEART, "08:15:05", 16'sd72);
        send_request(OP_STORE, 3'd3, KIND_SYS, "08:15:10", 16'sd120);
        send_request(OP_STORE, 3'd3, KIND_DIA, "08:15:10", 16'sd80);
        send_request(OP_STORE, 3'd3, KIND_RESP, "08:15:20", -16'sd1);
        send_request(OP_DUMP, 3'd3, KIND_TEMP, '0, '0);
    endtask

    // Overrun one ring by two so the dump starts mid-ring.
    task automatic test_ring_wrap();
        for (int n = 0; n < N_DEPTH + 2; n++)
            send_request(OP_STORE, 3'd1, KIND_SYS, {$urandom, $urandom}, 16'($urandom));
        send_request(OP_DUMP, 3'd1, KIND_TEMP, '0, '0);
    endtask

    task automatic test_random_traffic(input int count);
        int          pick;
        logic [2:0]  subj;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            // most traffic on two subjects so their rings wrap
            subj = ($urandom_range(0, 9) < 7) ? 3'($urandom_range(0, 1)) : 3'($urandom);
            if (pick < 18)
                send_request(OP_DUMP, subj, 3'($urandom), {$urandom, $urandom},
                             16'($urandom));
            else if (pick < 23)
                send_request(OP_STORE, subj, 3'($urandom_range(KIND_BAD_LO, KIND_BAD_HI)),
                             {$urandom, $urandom}, 16'($urandom));
            else
                send_request(OP_STORE, subj, 3'($urandom_range(KIND_TEMP, KIND_RESP)),
                             {$urandom, $urandom}, 16'($urandom));
        end
    endtask

    initial begin
        for (int c = 0; c < N_CHANNELS; c++) begin
            ring_fill[c]    = 0;
            ring_wr_slot[c] = 0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_dumps();
        test_store_extremes();
        test_ignored_stores();
        test_every_kind();
        test_ring_wrap();
        test_random_traffic(60);
        gaps_on = 1'b0;
        test_random_traffic(44);

        start <= 1'b0;
        wait (pending_dump_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_dump_q.size() != 0) begin
            $display("%0t: %0d dump results never arrived", $time, pending_dump_q.size());
            error_count++;
        end
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
